@@ src/ale_pkg.sv @@
// ale_pkg: shared types and constants for the array list engine
// no dependencies; imported by the interfaces and every module
`timescale 1ns / 1ps

package ale_pkg;

  localparam int unsigned ALE_DEPTH = 32;
  localparam int unsigned MAX_OUT   = 32;

  localparam int unsigned ACTION_W = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W   = 6;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 3'd0,
    ACT_DELETE  = 3'd1,
    ACT_REPLACE = 3'd2,
    ACT_SEARCH  = 3'd3,
    ACT_READ    = 3'd4
  } ale_action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_RANGE     = 2'd3
  } ale_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FINAL
  } ale_state_e;

endpackage

@@ src/ale_if.sv @@
// ale_if: valid/ready channels for command words and result words
// depends on ale_pkg for field widths
`timescale 1ns / 1ps

interface ale_in_if import ale_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACTION_W-1:0]      action;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, action, position, key, value, input ready);
  modport sink   (input valid, action, position, key, value, output ready);
endinterface

interface ale_out_if import ale_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [SLOT_W-1:0]        slot;
  logic signed [DATA_W-1:0] entry;
  logic [SLOT_W-1:0]        length;
  logic                     last;

  modport source (output valid, status, slot, entry, length, last, input ready);
  modport sink   (input valid, status, slot, entry, length, last, output ready);
endinterface

@@ src/ale_ram.sv @@
// ale_ram: list storage, one write port and one registered read port
// depends on ale_pkg for the data width
`timescale 1ns / 1ps

module ale_ram import ale_pkg::*; #(
  parameter int unsigned DEPTH = ALE_DEPTH,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic signed [DATA_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic signed [DATA_W-1:0] rdata_o
);

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/ale_ctrl.sv @@
// ale_ctrl: sequencer that walks the list one slot a cycle through the ram when
// not stalled, with the match compare, the result hold stage and output register
// depends on ale_pkg and ale_if
`timescale 1ns / 1ps

module ale_ctrl import ale_pkg::*; #(
  parameter int unsigned DEPTH = ALE_DEPTH,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned LW   = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  ale_in_if.sink                   in_i,
  ale_out_if.source                out_o,
  output logic                     mem_we_o,
  output logic [AW-1:0]            mem_waddr_o,
  output logic signed [DATA_W-1:0] mem_wdata_o,
  output logic                     mem_re_o,
  output logic [AW-1:0]            mem_raddr_o,
  input  logic signed [DATA_W-1:0] mem_rdata_i
);

  localparam int unsigned XW = ((LW > POS_W) ? LW : POS_W) + 1;

  ale_state_e state_q, state_d;
  ale_action_e op_q, op_d;

  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] ptr_q, ptr_d;
  logic [LW-1:0] j_q, j_d;
  logic signed [DATA_W-1:0] key_q, key_d, val_q, val_d;

  logic          pend_q, pend_d;
  logic          cap_q, cap_d;
  logic [AW-1:0] pend_idx_q, pend_idx_d;
  logic          hit_q, hit_d;

  logic                     hold_vld_q, hold_vld_d;
  logic [SLOT_W-1:0]        hold_slot_q, hold_slot_d;
  logic signed [DATA_W-1:0] hold_entry_q, hold_entry_d;
  logic [SLOT_W-1:0]        cnt_q, cnt_d;

  ale_status_e              fin_status_q, fin_status_d;
  logic [SLOT_W-1:0]        fin_slot_q, fin_slot_d;
  logic signed [DATA_W-1:0] fin_entry_q, fin_entry_d;

  logic                     out_valid_q, out_valid_d;
  ale_status_e              out_status_q, out_status_d;
  logic [SLOT_W-1:0]        out_slot_q, out_slot_d;
  logic signed [DATA_W-1:0] out_entry_q, out_entry_d;
  logic [SLOT_W-1:0]        out_length_q, out_length_d;
  logic                     out_last_q, out_last_d;

  logic          in_fire;
  logic          out_free;
  logic          go_run, go_final, run_done;
  logic [XW-1:0] pos_x, len_x;
  logic          match, stall, room;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  assign pos_x    = XW'(in_i.position);
  assign len_x    = XW'(len_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (go_final) begin
          state_d = S_FINAL;
        end else if (go_run) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (run_done) begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    op_d         = op_q;
    len_d        = len_q;
    ptr_d        = ptr_q;
    j_d          = j_q;
    key_d        = key_q;
    val_d        = val_q;
    pend_d       = pend_q;
    cap_d        = cap_q;
    pend_idx_d   = pend_idx_q;
    hit_d        = hit_q;
    hold_vld_d   = hold_vld_q;
    hold_slot_d  = hold_slot_q;
    hold_entry_d = hold_entry_q;
    cnt_d        = cnt_q;
    fin_status_d = fin_status_q;
    fin_slot_d   = fin_slot_q;
    fin_entry_d  = fin_entry_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_entry_d  = out_entry_q;
    out_length_d = out_length_q;
    out_last_d   = out_last_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = '0;
    mem_wdata_o  = '0;
    mem_re_o     = 1'b0;
    mem_raddr_o  = '0;
    go_run       = 1'b0;
    go_final     = 1'b0;
    run_done     = 1'b0;
    match        = pend_q && ((op_q == ACT_READ) || (mem_rdata_i == key_q));
    stall        = match && hold_vld_q && !out_free;
    room         = ({1'b0, cnt_q} + (SLOT_W + 1)'(match)) < (SLOT_W + 1)'(MAX_OUT);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          op_d         = ale_action_e'(in_i.action);
          key_d        = in_i.key;
          val_d        = in_i.value;
          j_d          = LW'(pos_x - XW'(1));
          pend_d       = 1'b0;
          cap_d        = 1'b0;
          hit_d        = 1'b0;
          hold_vld_d   = 1'b0;
          cnt_d        = '0;
          fin_slot_d   = '0;
          fin_entry_d  = '0;
          fin_status_d = STAT_RANGE;
          ptr_d        = '0;
          unique case (in_i.action)
            ACT_INSERT: begin
              if (len_q == LW'(DEPTH)) begin
                fin_status_d = STAT_FULL;
                go_final     = 1'b1;
              end else if (pos_x == '0 || pos_x > len_x + XW'(1)) begin
                go_final = 1'b1;
              end else begin
                ptr_d  = len_q;
                go_run = 1'b1;
              end
            end
            ACT_DELETE: begin
              if (pos_x == '0 || pos_x > len_x) begin
                go_final = 1'b1;
              end else begin
                ptr_d  = LW'(pos_x - XW'(1));
                go_run = 1'b1;
              end
            end
            ACT_REPLACE, ACT_SEARCH, ACT_READ: begin
              go_run = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      S_RUN: begin
        unique case (op_q)
          ACT_INSERT: begin
            // walk down from the top, each word moves up one slot
            if (pend_q) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = pend_idx_q;
              mem_wdata_o = mem_rdata_i;
            end
            if (ptr_q > j_q) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AW'(ptr_q - LW'(1));
              pend_d      = 1'b1;
              pend_idx_d  = AW'(ptr_q);
              ptr_d       = ptr_q - LW'(1);
            end else begin
              pend_d = 1'b0;
              if (!pend_q) begin
                mem_we_o     = 1'b1;
                mem_waddr_o  = AW'(j_q);
                mem_wdata_o  = val_q;
                len_d        = len_q + LW'(1);
                fin_status_d = STAT_OK;
                fin_slot_d   = SLOT_W'(j_q + LW'(1));
                fin_entry_d  = val_q;
                run_done     = 1'b1;
              end
            end
          end

          ACT_DELETE: begin
            // first read captures the removed word, the rest move down
            if (pend_q) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = pend_idx_q;
              mem_wdata_o = mem_rdata_i;
            end
            if (cap_q) begin
              fin_entry_d = mem_rdata_i;
            end
            if (ptr_q < len_q) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AW'(ptr_q);
              pend_d      = (ptr_q != j_q);
              cap_d       = (ptr_q == j_q);
              pend_idx_d  = AW'(ptr_q - LW'(1));
              ptr_d       = ptr_q + LW'(1);
            end else begin
              pend_d = 1'b0;
              cap_d  = 1'b0;
              if (!pend_q && !cap_q) begin
                len_d        = len_q - LW'(1);
                fin_status_d = STAT_OK;
                fin_slot_d   = SLOT_W'(j_q + LW'(1));
                run_done     = 1'b1;
              end
            end
          end

          ACT_REPLACE: begin
            if (pend_q && (mem_rdata_i == key_q)) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = pend_idx_q;
              mem_wdata_o = val_q;
              hit_d       = 1'b1;
            end
            if (ptr_q < len_q) begin
              mem_re_o    = 1'b1;
              mem_raddr_o = AW'(ptr_q);
              pend_d      = 1'b1;
              pend_idx_d  = AW'(ptr_q);
              ptr_d       = ptr_q + LW'(1);
            end else begin
              pend_d = 1'b0;
              if (!pend_q) begin
                fin_status_d = hit_q ? STAT_OK : STAT_NOT_FOUND;
                run_done     = 1'b1;
              end
            end
          end

          ACT_SEARCH, ACT_READ: begin
            // one hit stays held back until the next one shows it was not the last
            if (!stall) begin
              if (match) begin
                if (hold_vld_q) begin
                  out_valid_d  = 1'b1;
                  out_status_d = STAT_OK;
                  out_slot_d   = hold_slot_q;
                  out_entry_d  = hold_entry_q;
                  out_length_d = SLOT_W'(len_q);
                  out_last_d   = 1'b0;
                end
                hold_vld_d   = 1'b1;
                hold_slot_d  = SLOT_W'(pend_idx_q) + SLOT_W'(1);
                hold_entry_d = mem_rdata_i;
                cnt_d        = cnt_q + SLOT_W'(1);
              end
              if (ptr_q < len_q && room) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = AW'(ptr_q);
                pend_d      = 1'b1;
                pend_idx_d  = AW'(ptr_q);
                ptr_d       = ptr_q + LW'(1);
              end else begin
                pend_d = 1'b0;
                if (!pend_q) begin
                  fin_status_d = hold_vld_q ? STAT_OK : STAT_NOT_FOUND;
                  fin_slot_d   = hold_vld_q ? hold_slot_q : '0;
                  fin_entry_d  = hold_vld_q ? hold_entry_q : '0;
                  run_done     = 1'b1;
                end
              end
            end
          end

          default: run_done = 1'b1;
        endcase
      end

      S_FINAL: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = fin_status_q;
          out_slot_d   = fin_slot_q;
          out_entry_d  = fin_entry_q;
          out_length_d = SLOT_W'(len_q);
          out_last_d   = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      pend_q      <= 1'b0;
      cap_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pend_q      <= pend_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    ptr_q        <= ptr_d;
    j_q          <= j_d;
    key_q        <= key_d;
    val_q        <= val_d;
    pend_idx_q   <= pend_idx_d;
    hit_q        <= hit_d;
    hold_vld_q   <= hold_vld_d;
    hold_slot_q  <= hold_slot_d;
    hold_entry_q <= hold_entry_d;
    cnt_q        <= cnt_d;
    fin_status_q <= fin_status_d;
    fin_slot_q   <= fin_slot_d;
    fin_entry_q  <= fin_entry_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_entry_q  <= out_entry_d;
    out_length_q <= out_length_d;
    out_last_q   <= out_last_d;
  end

  assign in_i.ready   = (state_q == S_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.slot   = out_slot_q;
  assign out_o.entry  = out_entry_q;
  assign out_o.length = out_length_q;
  assign out_o.last   = out_last_q;

endmodule

@@ src/array_list_engine.sv @@
// array_list_engine: ordered list of signed 32-bit entries with insert, delete,
// replace, search and read-all commands
// depends on ale_pkg, ale_if, ale_ram and ale_ctrl
//
// in_i takes one command word (action, position, key, value); out_o returns
// one or more result words (status, slot, entry, length, last), with last set
// on the final word of each command. Unused action codes give no result.
// The sequencer walks the storage ram one slot per cycle (one read and one
// write port): insert and delete walk the slots from the position to the end,
// replace, search and read walk the whole list, and errors skip the walk. A
// search or read may also pause, and every command waits to finish, while the
// receiver stalls. in_i.ready is high only while the block is idle.
// Results leave through an output register; when out_o.ready is low the walk
// stops at the next word to emit and resumes when that register drains.
// Search and read return at most 32 words per command.
// Reset empties the list at once; no clearing pass, slots beyond the length
// are never read.
`timescale 1ns / 1ps

module array_list_engine import ale_pkg::*; #(
  parameter int unsigned DEPTH = ALE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ale_in_if.sink    in_i,
  ale_out_if.source out_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;

  ale_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  ale_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
